// File: design/msmc_pkg.sv
// ============================================================================
// msmc_pkg: shared types and constants for the MIPS subset multicycle CPU
// Action codes, opcode and function codes, and per-instruction cycle charges.
// ============================================================================
package msmc_pkg;

    typedef enum logic [2:0] {
        ACT_EXEC   = 3'd0,
        ACT_WR_REG = 3'd1,
        ACT_WR_MEM = 3'd2,
        ACT_RD_REG = 3'd3,
        ACT_RD_MEM = 3'd4,
        ACT_CLEAR  = 3'd5
    } action_t;

    localparam logic [5:0] OP_RTYPE = 6'h00;
    localparam logic [5:0] OP_ADDI  = 6'h08;
    localparam logic [5:0] OP_BEQ   = 6'h04;
    localparam logic [5:0] OP_BNE   = 6'h05;
    localparam logic [5:0] OP_LW    = 6'h23;
    localparam logic [5:0] OP_SW    = 6'h2B;

    localparam logic [5:0] FN_ADD = 6'h20;
    localparam logic [5:0] FN_SUB = 6'h22;
    localparam logic [5:0] FN_SLT = 6'h2A;

    localparam logic [2:0] CYC_NONE   = 3'd0;
    localparam logic [2:0] CYC_OTHER  = 3'd2;
    localparam logic [2:0] CYC_BRANCH = 3'd3;
    localparam logic [2:0] CYC_ALU    = 3'd4;
    localparam logic [2:0] CYC_STORE  = 3'd4;
    localparam logic [2:0] CYC_LOAD   = 3'd5;

endpackage

// File: design/mips_subset_multicycle_cpu.sv
// ============================================================================
// mips_subset_multicycle_cpu: MIPS subset processor, one instruction per beat
// Register file and data memory sit in synchronous RAMs; a short pipeline
// reads operands, executes and writes back, with forwarding into the operands.
// ============================================================================
//
//  channel  | handshake            | payload
//  ---------+----------------------+---------------------------------------------
//  input    | in_valid / in_ready  | action, instr_word, slot, load_value
//  output   | out_valid / out_ready| read_data, next_pc, branch_taken,
//           |                      | step_cycles, cycle_total, instr_total,
//           |                      | addr_error
//
// An accepted beat passes through the execute and memory stages into the
// output register. Items enter back to back, one per cycle while nothing
// downstream stalls, except that a load word or clear-all in the execute
// stage holds off the next beat until it leaves that stage, as the load data
// returns from the data memory port. After reset and after every clear-all
// the block sweeps max(32, MEM_WORDS) entries (256 by default), writing zeros
// to both RAMs, one entry a cycle, with in_ready low. A stalled output backs
// up stage by stage; a waiting result does not block a new beat while a stage
// is free. When a stalled load writes back, a register write waiting in the
// execute stage follows in the next cycle; the register file has one write port.
// ============================================================================
module mips_subset_multicycle_cpu #(
    parameter int MEM_WORDS = 256,
    parameter int PC_BITS   = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [2:0]         action,
    input  logic [31:0]        instr_word,
    input  logic [7:0]         slot,
    input  logic signed [31:0] load_value,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] read_data,
    output logic [15:0]        next_pc,
    output logic               branch_taken,
    output logic [2:0]         step_cycles,
    output logic [31:0]        cycle_total,
    output logic [31:0]        instr_total,
    output logic               addr_error
);
    import msmc_pkg::*;

    localparam int AW      = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
    localparam int SWEEP_N = (MEM_WORDS > 32) ? MEM_WORDS : 32;
    localparam int CW      = $clog2(SWEEP_N);
    localparam logic [CW-1:0]      SWEEP_LAST = CW'(SWEEP_N - 1);
    localparam logic [CW-1:0]      SWEEP_ONE  = CW'(1);
    localparam logic [31:0]        MEM_LIMIT  = 32'(MEM_WORDS);
    localparam logic [PC_BITS-1:0] PC_ONE     = PC_BITS'(1);

    // Storage.
    logic [31:0] rf_mem [32];
    logic [31:0] dm_mem [MEM_WORDS];
    logic [31:0] rf_qa_reg, rf_qb_reg;
    logic [31:0] dm_q_reg;

    // Architectural registers.
    logic [PC_BITS-1:0] pc_reg, pc_next;
    logic [31:0]        ctot_reg, ctot_next;
    logic [31:0]        itot_reg, itot_next;

    // Clearing sweep.
    logic          sweep_reg;
    logic [CW-1:0] sweep_cnt_reg;

    // Execute stage (A).
    logic        a_valid_reg;
    logic [2:0]  a_action_reg;
    logic [31:0] a_instr_reg;
    logic [7:0]  a_slot_reg;
    logic [31:0] a_val_reg;
    logic [4:0]  a_ra_reg;
    logic        a_fwd_a_reg, a_fwd_b_reg;
    logic [31:0] a_byp_a_reg, a_byp_b_reg;

    // Memory stage (B).
    logic        b_valid_reg;
    logic        b_lw_reg;
    logic [4:0]  b_rt_reg;
    logic        b_use_mem_reg;
    logic [31:0] b_rdata_reg;
    logic [15:0] b_pc_reg;
    logic        b_taken_reg;
    logic [2:0]  b_cyc_reg;
    logic [31:0] b_ctot_reg;
    logic [31:0] b_itot_reg;
    logic        b_err_reg;

    // Output register.
    logic        out_valid_reg;
    logic [31:0] out_rdata_reg;
    logic [15:0] out_pc_reg;
    logic        out_taken_reg;
    logic [2:0]  out_cyc_reg;
    logic [31:0] out_ctot_reg;
    logic [31:0] out_itot_reg;
    logic        out_err_reg;

    // Flow control.
    logic in_fire, a_move, b_move;
    logic a_is_lw, a_is_clear;

    // Execute stage decode and results.
    logic [5:0]  opc, fnc;
    logic [4:0]  rt, rd;
    logic [31:0] imm, opa, opb, alu_sum, addr_sum, mem_idx32, slot_idx32;
    logic        mem_ok, slot_ok, slot_is_reg;
    logic [PC_BITS-1:0] pc1;
    logic        a_rf_we;
    logic [4:0]  a_rf_wa;
    logic [31:0] a_rf_wd;
    logic        a_dm_we, a_dm_re;
    logic [31:0] a_dm_idx32;
    logic        res_lw, res_use_mem, res_taken, res_err, res_clear;
    logic [31:0] res_rdata;
    logic [2:0]  res_cyc;

    // Write-back from the memory stage.
    logic        b_lw_we, b_lw_write;
    logic [31:0] b_lw_val;

    // Input-side read addresses and forwarding.
    logic [4:0]  ra_in, rb_in;
    logic        fwd_a_next, fwd_b_next;
    logic [31:0] byp_a_next, byp_b_next;

    // RAM ports.
    logic        rf_we;
    logic [4:0]  rf_wa;
    logic [31:0] rf_wd;
    logic        dm_we, dm_re;
    logic [AW-1:0] dm_addr;
    logic [31:0] dm_wd;

    // ------------------------------------------------------------------------
    // Handshake
    // ------------------------------------------------------------------------
    assign a_is_lw    = (a_action_reg == ACT_EXEC) && (a_instr_reg[31:26] == OP_LW);
    assign a_is_clear = (a_action_reg == ACT_CLEAR);

    // A register write in the execute stage never shares the write port with
    // a load write-back from the memory stage; it waits until the load leaves.
    assign b_move   = b_valid_reg && (!out_valid_reg || out_ready);
    assign a_move   = a_valid_reg && (!b_valid_reg || b_move) && !(b_lw_we && a_rf_we);
    assign in_ready = !sweep_reg && (!a_valid_reg || a_move)
                      && !(a_valid_reg && (a_is_lw || a_is_clear));
    assign in_fire  = in_valid && in_ready;

    // ------------------------------------------------------------------------
    // Operand read addresses and forwarding captured at the accepting edge
    // ------------------------------------------------------------------------
    assign ra_in = (action == ACT_RD_REG) ? slot[4:0] : instr_word[25:21];
    assign rb_in = instr_word[20:16];

    assign b_lw_we  = b_valid_reg && b_lw_reg && (b_rt_reg != 5'd0);
    assign b_lw_val = b_err_reg ? 32'd0 : dm_q_reg;
    assign b_lw_write = b_move && b_lw_we;

    // The RAM returns the old word when written in the same edge, so the
    // newest pending write is captured beside the RAM data. The execute stage
    // is younger than the load in the memory stage and wins.
    always_comb
    begin
        fwd_a_next = 1'b0;
        byp_a_next = b_lw_val;
        priority if (a_move && a_rf_we && (a_rf_wa == ra_in))
        begin
            fwd_a_next = 1'b1;
            byp_a_next = a_rf_wd;
        end
        else if (b_lw_we && (b_rt_reg == ra_in))
        begin
            fwd_a_next = 1'b1;
        end
        fwd_b_next = 1'b0;
        byp_b_next = b_lw_val;
        priority if (a_move && a_rf_we && (a_rf_wa == rb_in))
        begin
            fwd_b_next = 1'b1;
            byp_b_next = a_rf_wd;
        end
        else if (b_lw_we && (b_rt_reg == rb_in))
        begin
            fwd_b_next = 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Execute stage
    // ------------------------------------------------------------------------
    assign opc = a_instr_reg[31:26];
    assign rt  = a_instr_reg[20:16];
    assign rd  = a_instr_reg[15:11];
    assign fnc = a_instr_reg[5:0];
    assign imm = {{16{a_instr_reg[15]}}, a_instr_reg[15:0]};

    assign opa = (a_ra_reg == 5'd0) ? 32'd0 : (a_fwd_a_reg ? a_byp_a_reg : rf_qa_reg);
    assign opb = (rt == 5'd0) ? 32'd0 : (a_fwd_b_reg ? a_byp_b_reg : rf_qb_reg);

    assign addr_sum    = opa + imm;
    assign mem_idx32   = {2'b00, addr_sum[31:2]};
    assign mem_ok      = mem_idx32 < MEM_LIMIT;
    assign slot_idx32  = 32'(a_slot_reg);
    assign slot_ok     = slot_idx32 < MEM_LIMIT;
    assign slot_is_reg = (a_slot_reg[7:5] == 3'd0);
    assign pc1         = pc_reg + PC_ONE;

    always_comb
    begin
        alu_sum = opa + opb;
        unique case (fnc)
            FN_SUB:  alu_sum = opa - opb;
            FN_SLT:  alu_sum = ($signed(opa) < $signed(opb)) ? 32'd1 : 32'd0;
            default: alu_sum = opa + opb;
        endcase
    end

    always_comb
    begin
        a_rf_we     = 1'b0;
        a_rf_wa     = rt;
        a_rf_wd     = 32'd0;
        a_dm_we     = 1'b0;
        a_dm_re     = 1'b0;
        a_dm_idx32  = mem_idx32;
        res_lw      = 1'b0;
        res_use_mem = 1'b0;
        res_taken   = 1'b0;
        res_err     = 1'b0;
        res_clear   = 1'b0;
        res_rdata   = 32'd0;
        res_cyc     = CYC_NONE;
        pc_next     = pc_reg;
        ctot_next   = ctot_reg;
        itot_next   = itot_reg;
        unique case (a_action_reg)
            ACT_EXEC:
            begin
                pc_next   = pc1;
                itot_next = itot_reg + 32'd1;
                unique case (opc)
                    OP_RTYPE:
                    begin
                        res_cyc = CYC_ALU;
                        if (fnc == FN_ADD || fnc == FN_SUB || fnc == FN_SLT)
                        begin
                            a_rf_wa   = rd;
                            a_rf_we   = (rd != 5'd0);
                            a_rf_wd   = alu_sum;
                            res_rdata = (rd != 5'd0) ? alu_sum : 32'd0;
                        end
                    end
                    OP_ADDI:
                    begin
                        res_cyc   = CYC_ALU;
                        a_rf_we   = (rt != 5'd0);
                        a_rf_wd   = addr_sum;
                        res_rdata = (rt != 5'd0) ? addr_sum : 32'd0;
                    end
                    OP_LW:
                    begin
                        res_cyc     = CYC_LOAD;
                        res_lw      = 1'b1;
                        a_dm_re     = mem_ok;
                        res_err     = !mem_ok;
                        res_use_mem = mem_ok && (rt != 5'd0);
                    end
                    OP_SW:
                    begin
                        res_cyc   = CYC_STORE;
                        a_dm_we   = mem_ok;
                        res_err   = !mem_ok;
                        res_rdata = mem_ok ? opb : 32'd0;
                    end
                    OP_BEQ, OP_BNE:
                    begin
                        res_cyc   = CYC_BRANCH;
                        res_taken = (opc == OP_BEQ) ? (opa == opb) : (opa != opb);
                        if (res_taken)
                        begin
                            pc_next = pc1 + imm[PC_BITS-1:0];
                        end
                    end
                    default:
                    begin
                        res_cyc = CYC_OTHER;
                    end
                endcase
                ctot_next = ctot_reg + 32'(res_cyc);
            end
            ACT_WR_REG:
            begin
                a_rf_wa   = a_slot_reg[4:0];
                a_rf_we   = slot_is_reg && (a_slot_reg[4:0] != 5'd0);
                a_rf_wd   = a_val_reg;
                res_rdata = a_rf_we ? a_val_reg : 32'd0;
            end
            ACT_WR_MEM:
            begin
                a_dm_idx32 = slot_idx32;
                a_dm_we    = slot_ok;
                res_err    = !slot_ok;
                res_rdata  = slot_ok ? a_val_reg : 32'd0;
            end
            ACT_RD_REG:
            begin
                res_rdata = slot_is_reg ? opa : 32'd0;
            end
            ACT_RD_MEM:
            begin
                a_dm_idx32  = slot_idx32;
                a_dm_re     = slot_ok;
                res_use_mem = slot_ok;
                res_err     = !slot_ok;
            end
            ACT_CLEAR:
            begin
                res_clear = 1'b1;
                pc_next   = '0;
                ctot_next = 32'd0;
                itot_next = 32'd0;
            end
            default:
            begin
                res_rdata = 32'd0;
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // RAM port selection
    // ------------------------------------------------------------------------
    always_comb
    begin
        rf_we = 1'b0;
        rf_wa = a_rf_wa;
        rf_wd = a_rf_wd;
        priority if (sweep_reg)
        begin
            rf_we = (32'(sweep_cnt_reg) < 32'd32);
            rf_wa = sweep_cnt_reg[4:0];
            rf_wd = 32'd0;
        end
        else if (a_move && a_rf_we)
        begin
            rf_we = 1'b1;
        end
        else if (b_lw_write)
        begin
            rf_we = 1'b1;
            rf_wa = b_rt_reg;
            rf_wd = b_lw_val;
        end
    end

    always_comb
    begin
        if (sweep_reg)
        begin
            dm_we   = (32'(sweep_cnt_reg) < MEM_LIMIT);
            dm_re   = 1'b0;
            dm_addr = sweep_cnt_reg[AW-1:0];
            dm_wd   = 32'd0;
        end
        else
        begin
            dm_we   = a_move && a_dm_we;
            dm_re   = a_move && a_dm_re;
            dm_addr = a_dm_idx32[AW-1:0];
            dm_wd   = (a_action_reg == ACT_WR_MEM) ? a_val_reg : opb;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rf_we)
        begin
            rf_mem[rf_wa] <= rf_wd;
        end
        if (in_fire)
        begin
            rf_qa_reg <= rf_mem[ra_in];
            rf_qb_reg <= rf_mem[rb_in];
        end
    end

    always_ff @(posedge clk)
    begin
        if (dm_we)
        begin
            dm_mem[dm_addr] <= dm_wd;
        end
        if (dm_re)
        begin
            dm_q_reg <= dm_mem[dm_addr];
        end
    end

    // ------------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            sweep_reg     <= 1'b1;
            sweep_cnt_reg <= '0;
            pc_reg        <= '0;
            ctot_reg      <= 32'd0;
            itot_reg      <= 32'd0;
        end
        else
        begin
            if (in_fire)
            begin
                a_valid_reg <= 1'b1;
            end
            else if (a_move)
            begin
                a_valid_reg <= 1'b0;
            end

            if (a_move)
            begin
                b_valid_reg <= 1'b1;
            end
            else if (b_move)
            begin
                b_valid_reg <= 1'b0;
            end

            if (b_move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (a_move)
            begin
                pc_reg   <= pc_next;
                ctot_reg <= ctot_next;
                itot_reg <= itot_next;
            end

            if (a_move && res_clear)
            begin
                sweep_reg     <= 1'b1;
                sweep_cnt_reg <= '0;
            end
            else if (sweep_reg)
            begin
                if (sweep_cnt_reg == SWEEP_LAST)
                begin
                    sweep_reg <= 1'b0;
                end
                else
                begin
                    sweep_cnt_reg <= sweep_cnt_reg + SWEEP_ONE;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            a_action_reg <= action;
            a_instr_reg  <= instr_word;
            a_slot_reg   <= slot;
            a_val_reg    <= load_value;
            a_ra_reg     <= ra_in;
            a_fwd_a_reg  <= fwd_a_next;
            a_fwd_b_reg  <= fwd_b_next;
            a_byp_a_reg  <= byp_a_next;
            a_byp_b_reg  <= byp_b_next;
        end
        if (a_move)
        begin
            b_lw_reg      <= res_lw;
            b_rt_reg      <= rt;
            b_use_mem_reg <= res_use_mem;
            b_rdata_reg   <= res_rdata;
            b_pc_reg      <= 16'(32'(pc_next));
            b_taken_reg   <= res_taken;
            b_cyc_reg     <= res_cyc;
            b_ctot_reg    <= ctot_next;
            b_itot_reg    <= itot_next;
            b_err_reg     <= res_err;
        end
        if (b_move)
        begin
            out_rdata_reg <= b_use_mem_reg ? dm_q_reg : b_rdata_reg;
            out_pc_reg    <= b_pc_reg;
            out_taken_reg <= b_taken_reg;
            out_cyc_reg   <= b_cyc_reg;
            out_ctot_reg  <= b_ctot_reg;
            out_itot_reg  <= b_itot_reg;
            out_err_reg   <= b_err_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign read_data    = out_rdata_reg;
    assign next_pc      = out_pc_reg;
    assign branch_taken = out_taken_reg;
    assign step_cycles  = out_cyc_reg;
    assign cycle_total  = out_ctot_reg;
    assign instr_total  = out_itot_reg;
    assign addr_error   = out_err_reg;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------

    // The execute-stage write and the load write-back never share an edge.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(a_move && a_rf_we && b_lw_write))
        else $error("register file write port claimed twice");

    // While the RAMs are being cleared no instruction is in the execute stage.
    assert property (@(posedge clk) disable iff (!rst_n)
        sweep_reg |-> !a_valid_reg)
        else $error("execute stage busy during clearing sweep");

    // A load in the execute stage is never followed by a beat in the same cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (a_valid_reg && a_is_lw) |-> !in_fire)
        else $error("beat accepted behind an unfinished load");

    // A beat in the memory stage that cannot move keeps its place.
    assert property (@(posedge clk) disable iff (!rst_n)
        (b_valid_reg && !b_move) |=> b_valid_reg)
        else $error("memory stage lost a beat");

endmodule

// File: tb/mips_subset_multicycle_cpu_tb.sv
// ============================================================================
// mips_subset_multicycle_cpu_tb: self-checking bench for the MIPS subset CPU
// Drives instruction and load/read beats through the valid/ready input channel,
// predicts every output beat with an independent model of the register file,
// data memory, program counter and cycle counters, and compares each field.
// ============================================================================
module mips_subset_multicycle_cpu_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import msmc_pkg::*;

    localparam int MEM_WORDS = 256;
    localparam int CYCLE_LIMIT = 300000;
    localparam int REPORT_LIMIT = 10;
    localparam logic [2:0] ACT_SPARE6 = 3'd6;
    localparam logic [2:0] ACT_SPARE7 = 3'd7;
    localparam logic [5:0] OP_UNUSED = 6'h3F;
    localparam logic [5:0] FN_UNUSED = 6'h3F;

    typedef struct packed {
        logic [2:0]  act;
        logic [31:0] word;
        logic [7:0]  slot;
        logic [31:0] value;
    } step_cmd_t;

    typedef struct packed {
        logic [31:0] data;
        logic [15:0] pc;
        logic        taken;
        logic [2:0]  cycles;
        logic [31:0] cyc_total;
        logic [31:0] ins_total;
        logic        err;
    } step_result_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [2:0]         action;
    logic [31:0]        instr_word;
    logic [7:0]         slot;
    logic signed [31:0] load_value;
    logic               out_valid;
    logic               out_ready;
    logic signed [31:0] read_data;
    logic [15:0]        next_pc;
    logic               branch_taken;
    logic [2:0]         step_cycles;
    logic [31:0]        cycle_total;
    logic [31:0]        instr_total;
    logic               addr_error;

    // Architectural state of the predictor.
    logic [31:0] model_gpr [32];
    logic [31:0] model_mem [MEM_WORDS];
    logic [15:0] model_pc;
    logic [31:0] model_cycles;
    logic [31:0] model_instrs;

    step_result_t expected_results [$];
    int mismatch_count = 0;
    int sim_cycles = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_off_cycles = 0;

    mips_subset_multicycle_cpu dut (.*);

    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void model_clear();
        foreach (model_gpr[i]) model_gpr[i] = '0;
        foreach (model_mem[i]) model_mem[i] = '0;
        model_pc = '0;
        model_cycles = '0;
        model_instrs = '0;
    endfunction

    // Register 0 is never written, so it keeps reading zero.
    function automatic void gpr_write(input logic [4:0] n, input logic [31:0] v);
        if (n != 5'd0)
            model_gpr[n] = v;
    endfunction

    function automatic step_result_t emulate_step(input step_cmd_t c);
        step_result_t r;
        logic [5:0]  op;
        logic [5:0]  fn;
        logic [4:0]  rs;
        logic [4:0]  rt;
        logic [4:0]  rd;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] imm;
        logic [31:0] addr;
        logic [31:0] alu;
        logic [15:0] pc_inc;
        logic        mem_ok;
        r = '0;
        op = c.word[31:26];
        rs = c.word[25:21];
        rt = c.word[20:16];
        rd = c.word[15:11];
        fn = c.word[5:0];
        imm = {{16{c.word[15]}}, c.word[15:0]};
        a = model_gpr[rs];
        b = model_gpr[rt];
        addr = a + imm;
        mem_ok = (addr >> 2) < MEM_WORDS;
        case (c.act)
            ACT_EXEC:
            begin
                pc_inc = model_pc + 16'd1;
                model_pc = pc_inc;
                case (op)
                    OP_RTYPE:
                    begin
                        r.cycles = CYC_ALU;
                        if (fn == FN_ADD || fn == FN_SUB || fn == FN_SLT)
                        begin
                            if (fn == FN_ADD)
                                alu = a + b;
                            else if (fn == FN_SUB)
                                alu = a - b;
                            else
                                alu = {31'd0, $signed(a) < $signed(b)};
                            gpr_write(rd, alu);
                            r.data = model_gpr[rd];
                        end
                    end
                    OP_ADDI:
                    begin
                        r.cycles = CYC_ALU;
                        gpr_write(rt, a + imm);
                        r.data = model_gpr[rt];
                    end
                    OP_LW:
                    begin
                        r.cycles = CYC_LOAD;
                        r.err = !mem_ok;
                        gpr_write(rt, mem_ok ? model_mem[addr[9:2]] : 32'd0);
                        r.data = model_gpr[rt];
                    end
                    OP_SW:
                    begin
                        r.cycles = CYC_STORE;
                        r.err = !mem_ok;
                        if (mem_ok)
                        begin
                            model_mem[addr[9:2]] = b;
                            r.data = b;
                        end
                    end
                    OP_BEQ, OP_BNE:
                    begin
                        r.cycles = CYC_BRANCH;
                        r.taken = (op == OP_BEQ) ? (a == b) : (a != b);
                        if (r.taken)
                            model_pc = pc_inc + imm[15:0];
                    end
                    default: r.cycles = CYC_OTHER;
                endcase
                model_cycles = model_cycles + r.cycles;
                model_instrs = model_instrs + 32'd1;
            end
            ACT_WR_REG:
            begin
                if (c.slot < 32)
                begin
                    gpr_write(c.slot[4:0], c.value);
                    r.data = model_gpr[c.slot[4:0]];
                end
            end
            ACT_WR_MEM:
            begin
                if (c.slot < MEM_WORDS)
                begin
                    model_mem[c.slot] = c.value;
                    r.data = c.value;
                end
                else
                    r.err = 1'b1;
            end
            ACT_RD_REG:
            begin
                if (c.slot < 32)
                    r.data = model_gpr[c.slot[4:0]];
            end
            ACT_RD_MEM:
            begin
                if (c.slot < MEM_WORDS)
                    r.data = model_mem[c.slot];
                else
                    r.err = 1'b1;
            end
            ACT_CLEAR: model_clear();
            default: ;
        endcase
        r.pc = model_pc;
        r.cyc_total = model_cycles;
        r.ins_total = model_instrs;
        return r;
    endfunction

    function automatic logic [31:0] alu_word(input logic [5:0] fn, input logic [4:0] rs,
                                             input logic [4:0] rt, input logic [4:0] rd);
        return {OP_RTYPE, rs, rt, rd, 5'd0, fn};
    endfunction

    function automatic logic [31:0] imm_word(input logic [5:0] op, input logic [4:0] rs,
                                             input logic [4:0] rt, input logic [15:0] imm);
        return {op, rs, rt, imm};
    endfunction

    function automatic step_cmd_t make_cmd(input logic [2:0] act, input logic [31:0] word,
                                           input logic [7:0] idx, input logic [31:0] value);
        step_cmd_t c;
        c.act = act;
        c.word = word;
        c.slot = idx;
        c.value = value;
        return c;
    endfunction

    // Mostly the low registers, so that back-to-back instructions share operands.
    function automatic logic [4:0] pick_reg();
        logic [4:0] n;
        if ($urandom_range(3) != 0)
            n = $urandom_range(7);
        else
            n = $urandom_range(31);
        return n;
    endfunction

    function automatic step_cmd_t random_cmd();
        step_cmd_t c;
        int pick;
        int sel;
        logic [5:0] op;
        logic [5:0] fn;
        logic [4:0] rs;
        logic [4:0] rt;
        logic [4:0] rd;
        logic [15:0] imm;
        c = make_cmd(ACT_EXEC, $urandom, $urandom, $urandom);
        pick = $urandom_range(99);
        rs = pick_reg();
        rt = pick_reg();
        rd = pick_reg();
        imm = $urandom;
        if (pick < 1)
            c.act = ACT_CLEAR;
        else if (pick < 2)
            c.act = $urandom_range(1) ? ACT_SPARE6 : ACT_SPARE7;
        else if (pick < 12)
        begin
            c.act = ACT_WR_REG;
            if ($urandom_range(9) != 0)
                c.slot = $urandom_range(31);
            // Small values keep register-based addresses inside the memory.
            if ($urandom_range(1) != 0)
                c.value = $urandom_range(1023);
        end
        else if (pick < 20)
            c.act = ACT_WR_MEM;
        else if (pick < 26)
        begin
            c.act = ACT_RD_REG;
            if ($urandom_range(4) != 0)
                c.slot = $urandom_range(31);
        end
        else if (pick < 32)
            c.act = ACT_RD_MEM;
        else
        begin
            sel = $urandom_range(99);
            if (sel < 12)
                c.word = alu_word(FN_ADD, rs, rt, rd);
            else if (sel < 22)
                c.word = alu_word(FN_SUB, rs, rt, rd);
            else if (sel < 30)
                c.word = alu_word(FN_SLT, rs, rt, rd);
            else if (sel < 42)
                c.word = imm_word(OP_ADDI, rs, rt, imm);
            else if (sel < 70)
            begin
                op = (sel < 57) ? OP_LW : OP_SW;
                pick = $urandom_range(99);
                if (pick < 60)
                begin
                    rs = 5'd0;
                    imm = $urandom_range(1023);
                end
                else if (pick < 85)
                    imm = $urandom_range(1023);
                c.word = imm_word(op, rs, rt, imm);
            end
            else if (sel < 78)
                c.word = imm_word(OP_BEQ, rs, rt, imm);
            else if (sel < 86)
                c.word = imm_word(OP_BNE, rs, rt, imm);
            else if (sel < 90)
            begin
                do fn = $urandom_range(63);
                while (fn == FN_ADD || fn == FN_SUB || fn == FN_SLT);
                c.word = {alu_word(fn, rs, rt, rd)} | {21'd0, 5'($urandom), 6'd0};
            end
            else if (sel < 95)
            begin
                do op = $urandom_range(63);
                while (op == OP_RTYPE || op == OP_ADDI || op == OP_LW || op == OP_SW
                       || op == OP_BEQ || op == OP_BNE);
                c.word = imm_word(op, rs, rt, imm);
            end
        end
        return c;
    endfunction

    // The previous beat may have been accepted in this same time step, so valid
    // is only ever assigned once here: low for an idle cycle or high for the next beat.
    task automatic issue_beat(input step_cmd_t c);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        action <= c.act;
        instr_word <= c.word;
        slot <= c.slot;
        load_value <= c.value;
        do @(posedge clk);
        while (!in_ready);
        expected_results.push_back(emulate_step(c));
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
            $display("%s", msg);
    endtask

    task automatic test_directed();
        step_cmd_t seq [$];
        send_idle_pct = 0;
        recv_idle_pct = 0;
        seq.push_back(make_cmd(ACT_WR_REG, '0, 8'd1, 32'h7FFF_FFFF));
        seq.push_back(make_cmd(ACT_WR_REG, '0, 8'd2, 32'h8000_0000));
        seq.push_back(make_cmd(ACT_WR_REG, '0, 8'd0, 32'd12345));
        seq.push_back(make_cmd(ACT_WR_REG, '0, 8'd255, 32'hFFFF_FFFF));
        seq.push_back(make_cmd(ACT_RD_REG, '0, 8'd0, '0));
        seq.push_back(make_cmd(ACT_RD_REG, '0, 8'd200, '0));
        seq.push_back(make_cmd(ACT_WR_MEM, '0, 8'd0, 32'hFFFF_FFFF));
        seq.push_back(make_cmd(ACT_WR_MEM, '0, 8'd255, 32'h8000_0000));
        seq.push_back(make_cmd(ACT_EXEC, alu_word(FN_ADD, 5'd1, 5'd2, 5'd3), '0, '0));
        seq.push_back(make_cmd(ACT_EXEC, alu_word(FN_SUB, 5'd2, 5'd1, 5'd4), '0, '0));
        seq.push_back(make_cmd(ACT_EXEC, alu_word(FN_SLT, 5'd2, 5'd1, 5'd5), '0, '0));
        seq.push_back(make_cmd(ACT_EXEC, alu_word(FN_ADD, 5'd1, 5'd1, 5'd0), '0, '0));
        seq.push_back(make_cmd(ACT_EXEC, imm_word(OP_ADDI, 5'd1, 5'd6, 16'h7FFF), '0, '0));
        seq.push_back(make_cmd(ACT_EXEC, imm_word(OP_ADDI, 5'd0, 5'd7, 16'h8000), '0, '0));
        // Unaligned byte address: the two low bits are dropped, so this reads word 255.
        seq.push_back(make_cmd(ACT_EXEC, imm_word(OP_LW, 5'd0, 5'd8, 16'h03FF), '0, '0));
        seq.push_back(make_cmd(ACT_EXEC, imm_word(OP_LW, 5'd0, 5'd9, 16'h0400), '0, '0));
        seq.push_back(make_cmd(ACT_EXEC, imm_word(OP_LW, 5'd0, 5'd10, 16'hFFFC), '0, '0));
        seq.push_back(make_cmd(ACT_EXEC, imm_word(OP_SW, 5'd0, 5'd1, 16'h0004), '0, '0));
        seq.push_back(make_cmd(ACT_EXEC, imm_word(OP_SW, 5'd0, 5'd2, 16'h8000), '0, '0));
        seq.push_back(make_cmd(ACT_EXEC, imm_word(OP_LW, 5'd0, 5'd11, 16'h0004), '0, '0));
        seq.push_back(make_cmd(ACT_EXEC, imm_word(OP_BEQ, 5'd0, 5'd0, 16'hFFFF), '0, '0));
        seq.push_back(make_cmd(ACT_EXEC, imm_word(OP_BNE, 5'd1, 5'd1, 16'h0005), '0, '0));
        seq.push_back(make_cmd(ACT_EXEC, imm_word(OP_BNE, 5'd1, 5'd2, 16'h7FFF), '0, '0));
        seq.push_back(make_cmd(ACT_EXEC, alu_word(FN_UNUSED, 5'd1, 5'd2, 5'd12), '0, '0));
        seq.push_back(make_cmd(ACT_EXEC, imm_word(OP_UNUSED, 5'd1, 5'd13, 16'h1234), '0, '0));
        seq.push_back(make_cmd(ACT_SPARE6, '1, 8'd1, '1));
        seq.push_back(make_cmd(ACT_SPARE7, '1, 8'd2, '1));
        seq.push_back(make_cmd(ACT_CLEAR, '0, '0, '0));
        seq.push_back(make_cmd(ACT_RD_MEM, '0, 8'd1, '0));
        foreach (seq[i])
            issue_beat(seq[i]);
        drain_results();
    endtask

    task automatic test_random_mix(input int beats, input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        repeat (beats)
            issue_beat(random_cmd());
        drain_results();
    endtask

    // The receiver stops for a long stretch while beats keep coming, so the
    // pipeline fills and input ready must drop until the output moves again.
    task automatic test_output_stall();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_off_cycles = 300;
        repeat (40)
            issue_beat(random_cmd());
        drain_results();
    endtask

    initial
    begin
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_cycles > 0)
            begin
                hold_off_cycles--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin : result_check
        step_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
                report_mismatch($sformatf("unexpected result beat: data=%h pc=%h",
                                          read_data, next_pc));
            else
            begin
                want = expected_results.pop_front();
                if (read_data !== want.data || next_pc !== want.pc
                    || branch_taken !== want.taken || step_cycles !== want.cycles
                    || cycle_total !== want.cyc_total || instr_total !== want.ins_total
                    || addr_error !== want.err)
                    report_mismatch($sformatf({"result beat differs: exp data=%h pc=%h tk=%b ",
                                               "cyc=%0d ctot=%h itot=%h err=%b | got data=%h ",
                                               "pc=%h tk=%b cyc=%0d ctot=%h itot=%h err=%b"},
                                              want.data, want.pc, want.taken, want.cycles,
                                              want.cyc_total, want.ins_total, want.err,
                                              read_data, next_pc, branch_taken, step_cycles,
                                              cycle_total, instr_total, addr_error));
            end
        end
    end

    always @(posedge clk)
    begin
        sim_cycles++;
        if (sim_cycles > CYCLE_LIMIT)
        begin
            $display("mips_subset_multicycle_cpu: mismatch");
            $finish;
        end
    end

    initial
    begin
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        action <= ACT_EXEC;
        instr_word <= '0;
        slot <= '0;
        load_value <= '0;
        model_clear();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_random_mix(530, 23, 50);
        test_random_mix(530, 50, 23);
        test_random_mix(530, 0, 0);
        test_output_stall();

        repeat (20) @(posedge clk);
        if (mismatch_count == 0)
            $display("mips_subset_multicycle_cpu: match");
        else
            $display("mips_subset_multicycle_cpu: mismatch");
        $finish;
    end

endmodule
